[src/uitp_pkg.sv]
// Shared types and constants for the user-info record parser.
// Holds field codes, TLV type codes, the capability table and the result struct.
// No dependencies.
`timescale 1ns / 1ps

package uitp_pkg;

  // Name characters kept per record is NAME_MAX_LEN-1
  localparam int NAME_MAX_LEN = 32;
  // Extra-info bytes emitted per extra TLV
  localparam int EXTRA_BYTES  = 37;

  localparam logic [15:0] CAP_UNKNOWN = 16'hff00;
  localparam logic [3:0]  CAP_LAST_K  = 4'hf;

  // TLV type codes
  localparam logic [15:0] TLV_FLAGS   = 16'h0001;
  localparam logic [15:0] TLV_MEMBER  = 16'h0002;
  localparam logic [15:0] TLV_ONLINE  = 16'h0003;
  localparam logic [15:0] TLV_IDLE    = 16'h0004;
  localparam logic [15:0] TLV_STATUS  = 16'h0006;
  localparam logic [15:0] TLV_IPADDR  = 16'h000a;
  localparam logic [15:0] TLV_EXTRA   = 16'h000c;
  localparam logic [15:0] TLV_CAPS    = 16'h000d;
  localparam logic [15:0] TLV_SESS_A  = 16'h000f;
  localparam logic [15:0] TLV_SESS_B  = 16'h0010;

  typedef enum logic [3:0] {
    FC_NAME_CHAR = 4'd0,
    FC_WARN      = 4'd1,
    FC_FLAGS     = 4'd2,
    FC_MEMBER    = 4'd3,
    FC_ONLINE    = 4'd4,
    FC_IDLE      = 4'd5,
    FC_STATUS    = 4'd6,
    FC_IPADDR    = 4'd7,
    FC_EXTRA     = 4'd8,
    FC_CAPS      = 4'd9,
    FC_SESSION   = 4'd10,
    FC_END       = 4'd11
  } field_code_t;

  typedef struct packed {
    logic        vld;
    field_code_t code;
    logic [31:0] value;
    logic [5:0]  index;
    logic        last;
  } uitp_res_t;

  // Stored capability identifiers, 16 bytes each
  localparam logic [7:0] CAP_TABLE [0:7][0:15] = '{
    '{8'h09,8'h46,8'h13,8'h46,8'h4c,8'h7f,8'h11,8'hd1,
      8'h82,8'h22,8'h44,8'h45,8'h53,8'h54,8'h00,8'h00},
    '{8'h09,8'h46,8'h13,8'h41,8'h4c,8'h7f,8'h11,8'hd1,
      8'h82,8'h22,8'h44,8'h45,8'h53,8'h54,8'h00,8'h00},
    '{8'h09,8'h46,8'h13,8'h45,8'h4c,8'h7f,8'h11,8'hd1,
      8'h82,8'h22,8'h44,8'h45,8'h53,8'h54,8'h00,8'h00},
    '{8'h74,8'h8f,8'h24,8'h20,8'h62,8'h87,8'h11,8'hd1,
      8'h82,8'h22,8'h44,8'h45,8'h53,8'h54,8'h00,8'h00},
    '{8'h09,8'h46,8'h13,8'h48,8'h4c,8'h7f,8'h11,8'hd1,
      8'h82,8'h22,8'h44,8'h45,8'h53,8'h54,8'h00,8'h00},
    '{8'h09,8'h46,8'h13,8'h43,8'h4c,8'h7f,8'h11,8'hd1,
      8'h82,8'h22,8'h44,8'h45,8'h53,8'h54,8'h00,8'h00},
    '{8'h09,8'h46,8'h13,8'h47,8'h4c,8'h7f,8'h11,8'hd1,
      8'h82,8'h22,8'h44,8'h45,8'h53,8'h54,8'h00,8'h00},
    '{8'h09,8'h46,8'h13,8'h4a,8'h4c,8'h7f,8'h11,8'hd1,
      8'h82,8'h22,8'h44,8'h45,8'h53,8'h54,8'h00,8'h00}
  };

endpackage

[src/uitp_core.sv]
// Parser state registers and per-byte next-state / result logic.
// Depends on uitp_pkg.
`timescale 1ns / 1ps

module uitp_core #(
  parameter int NAME_MAX_LEN = uitp_pkg::NAME_MAX_LEN,
  parameter int EXTRA_BYTES  = uitp_pkg::EXTRA_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic [7:0]          data_byte,
  input  logic                record_start,
  output uitp_pkg::uitp_res_t res
);
  import uitp_pkg::*;

  typedef enum logic [8:0] {
    PH_NLEN = 9'b000000001,
    PH_NAME = 9'b000000010,
    PH_WARN = 9'b000000100,
    PH_CNT  = 9'b000001000,
    PH_TYPE = 9'b000010000,
    PH_LEN  = 9'b000100000,
    PH_VAL  = 9'b001000000,
    PH_PEND = 9'b010000000,
    PH_DONE = 9'b100000000
  } phase_t;

  phase_t      phase_r, phase_nxt, ph_cur;
  logic [15:0] fbc_r, fbc_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] type_r, type_nxt;
  logic [15:0] len_r, len_nxt;
  logic [31:0] vs_r, vs_nxt;
  logic [7:0]  nlen_r, nlen_nxt;
  logic        flags_r, flags_nxt;
  logic [7:0]  match_r, match_nxt;
  logic [15:0] mask_r, mask_nxt;
  logic [15:0] tot_r, tot_nxt;

  logic [15:0] vs_w;
  logic [31:0] vs_v;
  logic [15:0] pos;
  logic [3:0]  cap_k;
  logic [7:0]  match_tmp;
  logic        word_done;
  logic        last_val;
  logic        do_end_tlv;
  logic        do_finish;

  // Process one accepted byte
  always_comb begin
    phase_nxt  = phase_r;
    fbc_nxt    = fbc_r;
    rem_nxt    = rem_r;
    type_nxt   = type_r;
    len_nxt    = len_r;
    vs_nxt     = vs_r;
    nlen_nxt   = nlen_r;
    flags_nxt  = flags_r;
    match_nxt  = match_r;
    mask_nxt   = mask_r;
    tot_nxt    = tot_r;
    res        = '0;
    ph_cur     = phase_r;
    vs_w       = '0;
    vs_v       = '0;
    pos        = '0;
    cap_k      = '0;
    match_tmp  = '0;
    word_done  = 1'b0;
    last_val   = 1'b0;
    do_end_tlv = 1'b0;
    do_finish  = 1'b0;

    if (in_fire) begin
      // Flush an end result held back by a collision
      if (phase_r == PH_PEND) begin
        res.vld   = 1'b1;
        res.code  = FC_END;
        res.value = {16'b0, tot_r};
        res.last  = 1'b1;
        phase_nxt = PH_DONE;
      end
      // Restart the parser on a record start
      if (record_start) begin
        phase_nxt = PH_NLEN;
        fbc_nxt   = '0;
        rem_nxt   = '0;
        type_nxt  = '0;
        len_nxt   = '0;
        vs_nxt    = '0;
        nlen_nxt  = '0;
        flags_nxt = 1'b0;
        match_nxt = 8'hff;
        mask_nxt  = '0;
        tot_nxt   = '0;
      end

      if (record_start || !(phase_r == PH_PEND || phase_r == PH_DONE)) begin
        // Count bytes, saturating
        if (tot_nxt != 16'hffff) begin
          tot_nxt = tot_nxt + 16'd1;
        end
        ph_cur    = phase_nxt;
        vs_w      = {vs_nxt[7:0], data_byte};
        word_done = (fbc_nxt != 16'd0);
        case (ph_cur)
          PH_NLEN: begin
            nlen_nxt  = data_byte;
            fbc_nxt   = '0;
            vs_nxt    = '0;
            phase_nxt = (data_byte != 8'd0) ? PH_NAME : PH_WARN;
          end
          PH_NAME: begin
            if (fbc_nxt < 16'(NAME_MAX_LEN - 1)) begin
              res.vld   = 1'b1;
              res.code  = FC_NAME_CHAR;
              res.value = {24'b0, data_byte};
              res.index = fbc_nxt[5:0];
            end
            fbc_nxt = fbc_nxt + 16'd1;
            if (fbc_nxt >= {8'b0, nlen_nxt}) begin
              fbc_nxt   = '0;
              phase_nxt = PH_WARN;
            end
          end
          PH_WARN: begin
            if (word_done) begin
              res.vld   = 1'b1;
              res.code  = FC_WARN;
              res.value = {16'b0, vs_w};
              vs_nxt    = '0;
              fbc_nxt   = '0;
              phase_nxt = PH_CNT;
            end else begin
              vs_nxt  = {16'b0, vs_w};
              fbc_nxt = fbc_nxt + 16'd1;
            end
          end
          PH_CNT: begin
            if (word_done) begin
              rem_nxt = vs_w;
              vs_nxt  = '0;
              fbc_nxt = '0;
              if (vs_w == 16'd0) begin
                do_finish = 1'b1;
              end else begin
                phase_nxt = PH_TYPE;
              end
            end else begin
              vs_nxt  = {16'b0, vs_w};
              fbc_nxt = fbc_nxt + 16'd1;
            end
          end
          PH_TYPE: begin
            if (word_done) begin
              type_nxt = vs_w;
              vs_nxt   = '0;
              fbc_nxt  = '0;
              // Padding pairs of type zero are skipped
              if (vs_w != 16'd0) begin
                phase_nxt = PH_LEN;
              end
            end else begin
              vs_nxt  = {16'b0, vs_w};
              fbc_nxt = fbc_nxt + 16'd1;
            end
          end
          PH_LEN: begin
            if (word_done) begin
              len_nxt = vs_w;
              vs_nxt  = '0;
              fbc_nxt = '0;
              if (type_nxt == TLV_CAPS) begin
                mask_nxt  = '0;
                match_nxt = 8'hff;
              end
              if (vs_w == 16'd0) begin
                do_end_tlv = 1'b1;
              end else begin
                phase_nxt = PH_VAL;
              end
            end else begin
              vs_nxt  = {16'b0, vs_w};
              fbc_nxt = fbc_nxt + 16'd1;
            end
          end
          PH_VAL: begin
            pos      = fbc_nxt;
            vs_v     = {vs_nxt[23:0], data_byte};
            vs_nxt   = vs_v;
            last_val = ((pos + 16'd1) == len_nxt);
            case (type_nxt)
              TLV_FLAGS: begin
                if (!flags_nxt && pos == 16'd1) begin
                  res.vld   = 1'b1;
                  res.code  = FC_FLAGS;
                  res.value = {16'b0, vs_v[15:0]};
                end
              end
              TLV_MEMBER: begin
                if (pos == 16'd3) begin
                  res.vld   = 1'b1;
                  res.code  = FC_MEMBER;
                  res.value = vs_v;
                end
              end
              TLV_ONLINE: begin
                if (pos == 16'd3) begin
                  res.vld   = 1'b1;
                  res.code  = FC_ONLINE;
                  res.value = vs_v;
                end
              end
              TLV_IDLE: begin
                if (pos == 16'd1) begin
                  res.vld   = 1'b1;
                  res.code  = FC_IDLE;
                  res.value = {16'b0, vs_v[15:0]};
                end
              end
              TLV_STATUS: begin
                if (pos == 16'd3) begin
                  res.vld   = 1'b1;
                  res.code  = FC_STATUS;
                  res.value = {16'b0, vs_v[15:0]};
                end
              end
              TLV_IPADDR: begin
                if (pos == 16'd3) begin
                  res.vld   = 1'b1;
                  res.code  = FC_IPADDR;
                  res.value = vs_v;
                end
              end
              TLV_EXTRA: begin
                if (pos < 16'(EXTRA_BYTES)) begin
                  res.vld   = 1'b1;
                  res.code  = FC_EXTRA;
                  res.value = {24'b0, data_byte};
                  res.index = pos[5:0];
                end
              end
              TLV_CAPS: begin
                // Drop identifiers whose byte at this offset differs
                cap_k = pos[3:0];
                for (int y = 0; y < 8; y++) begin
                  match_tmp[y] = match_nxt[y] & (CAP_TABLE[y][cap_k] == data_byte);
                end
                match_nxt = match_tmp;
                if (cap_k == CAP_LAST_K) begin
                  mask_nxt  = mask_nxt | ((match_tmp != 8'd0) ? {8'b0, match_tmp}
                                                                : CAP_UNKNOWN);
                  match_nxt = 8'hff;
                end
                if (last_val) begin
                  if (cap_k != CAP_LAST_K) begin
                    mask_nxt = mask_nxt | CAP_UNKNOWN;
                  end
                  res.vld   = 1'b1;
                  res.code  = FC_CAPS;
                  res.value = {16'b0, mask_nxt};
                end
              end
              TLV_SESS_A, TLV_SESS_B: begin
                if (pos == 16'd3) begin
                  res.vld   = 1'b1;
                  res.code  = FC_SESSION;
                  res.value = vs_v;
                end
              end
              default: begin
              end
            endcase
            fbc_nxt = pos + 16'd1;
            if (last_val) begin
              do_end_tlv = 1'b1;
            end
          end
          default: begin
          end
        endcase

        // Close the current TLV
        if (do_end_tlv) begin
          if (type_nxt == TLV_FLAGS) begin
            flags_nxt = 1'b1;
          end
          rem_nxt = rem_nxt - 16'd1;
          fbc_nxt = '0;
          vs_nxt  = '0;
          if (rem_nxt == 16'd0) begin
            do_finish = 1'b1;
          end else begin
            phase_nxt = PH_TYPE;
          end
        end

        // End of record: hold the end result if a field already goes out
        if (do_finish) begin
          if (res.vld) begin
            phase_nxt = PH_PEND;
          end else begin
            res.vld   = 1'b1;
            res.code  = FC_END;
            res.value = {16'b0, tot_nxt};
            res.index = '0;
            res.last  = 1'b1;
            phase_nxt = PH_DONE;
          end
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NLEN;
      fbc_r   <= '0;
      rem_r   <= '0;
      type_r  <= '0;
      len_r   <= '0;
      vs_r    <= '0;
      nlen_r  <= '0;
      flags_r <= 1'b0;
      match_r <= 8'hff;
      mask_r  <= '0;
      tot_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      fbc_r   <= fbc_nxt;
      rem_r   <= rem_nxt;
      type_r  <= type_nxt;
      len_r   <= len_nxt;
      vs_r    <= vs_nxt;
      nlen_r  <= nlen_nxt;
      flags_r <= flags_nxt;
      match_r <= match_nxt;
      mask_r  <= mask_nxt;
      tot_r   <= tot_nxt;
    end
  end

endmodule

[src/user_info_tlv_parser.sv]
// Results are registered in the output register, or in the skid stage on a stall.
// One byte per cycle while in_tready; the parser state updates in the cycle it is taken.
// in_tready drops only while both the output register and the skid stage hold results.
// Reset (rst_n low, synchronous): parser waits for a name-length byte, output empties.
// Top level of the user-info record parser; depends on uitp_pkg and uitp_core.
`timescale 1ns / 1ps

module user_info_tlv_parser #(
  parameter int NAME_MAX_LEN = uitp_pkg::NAME_MAX_LEN,
  parameter int EXTRA_BYTES  = uitp_pkg::EXTRA_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] record_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] field_value, [37:32] item_index, [39:38] zero
  output logic [3:0]  out_tuser,  // [3:0] field_code
  output logic        out_tlast   // last
);
  import uitp_pkg::*;

  logic      in_fire;
  logic      out_fire;
  uitp_res_t res;
  uitp_res_t out_r;
  uitp_res_t skid_r;
  logic      out_vld_r;
  logic      skid_vld_r;

  assign in_tready = ~skid_vld_r;
  assign in_fire   = in_tvalid & in_tready;
  assign out_fire  = out_vld_r & out_tready;

  uitp_core #(
    .NAME_MAX_LEN (NAME_MAX_LEN),
    .EXTRA_BYTES  (EXTRA_BYTES)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .data_byte    (in_tdata),
    .record_start (in_tuser[0]),
    .res          (res)
  );

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_fire) begin
        out_r      <= skid_r;
        skid_vld_r <= 1'b0;
      end
    end else if (in_fire && res.vld) begin
      if (!out_vld_r || out_fire) begin
        out_r     <= res;
        out_vld_r <= 1'b1;
      end else begin
        skid_r     <= res;
        skid_vld_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_r.index, out_r.value};
  assign out_tuser  = out_r.code;
  assign out_tlast  = out_r.last;

endmodule

[src/uitp_checker.sv]
// Port-level checks for user_info_tlv_parser, attached by bind.
// Depends on uitp_pkg.
`timescale 1ns / 1ps

module uitp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [3:0]  out_tuser,
  input logic        out_tlast
);
  import uitp_pkg::*;

  // Output is empty the cycle after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
                                  && $stable(out_tlast))
    else $error("stalled result changed");

  // tlast marks exactly the end-of-record result
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == FC_END)))
    else $error("tlast does not match end code");

  // Only name characters and extra bytes carry an index
  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != FC_NAME_CHAR && out_tuser != FC_EXTRA
      |-> out_tdata[37:32] == 6'd0)
    else $error("index on a field without one");

  // Byte and 16-bit fields keep the upper value bits clear
  a_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == FC_NAME_CHAR || out_tuser == FC_EXTRA || out_tuser == FC_WARN
      || out_tuser == FC_FLAGS || out_tuser == FC_IDLE || out_tuser == FC_STATUS
      || out_tuser == FC_CAPS || out_tuser == FC_END) |-> out_tdata[31:16] == 16'd0)
    else $error("narrow field has upper bits set");

endmodule

bind user_info_tlv_parser uitp_checker u_uitp_checker (.*);
